/* rtl/hmsm_pkg.sv */
`default_nettype none

package hmsm_pkg;

  localparam int NUM_SIGS = 13;
  localparam int SIG_MAX_LEN = 28;
  localparam int POS_W = 9;
  localparam int IDX_W = $clog2(SIG_MAX_LEN);
  localparam int CODE_W = 4;

  // Bytes at or past this position never reach a comparator.
  localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(348);
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef logic [NUM_SIGS-1:0] sig_mask_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [SIG_MAX_LEN*8-1:0] sig_row_t;

  localparam code_t CODE_UNKNOWN = '0;

  localparam pos_t SIG_OFFSET [NUM_SIGS] = '{
    9'd0, 9'd0, 9'd128, 9'd0, 9'd0, 9'd54, 9'd344, 9'd344,
    9'd0, 9'd0, 9'd0, 9'd0, 9'd0
  };

  localparam logic [IDX_W:0] SIG_LENGTH [NUM_SIGS] = '{
    6'd13, 6'd2, 6'd4, 6'd11, 6'd14, 6'd2, 6'd4, 6'd4,
    6'd13, 6'd4, 6'd4, 6'd4, 6'd28
  };

  // Last position holding a nonzero byte; a file that ends before it cannot match,
  // since the missing positions read as zero.
  localparam pos_t SIG_NEED [NUM_SIGS] = '{
    9'd12, 9'd1, 9'd131, 9'd10, 9'd13, 9'd55, 9'd346, 9'd346,
    9'd12, 9'd3, 9'd1, 9'd3, 9'd27
  };

  // Signature bytes, first byte in the top byte lane.
  localparam sig_row_t SIG_BYTES [NUM_SIGS] = '{
    {8'h21, 8'h20, 8'h54, 8'h59, 8'h50, 8'h45, 8'h44, 8'h53, 8'h54, 8'h52,
     8'h45, 8'h41, 8'h4D, {15{8'h00}}},
    {8'h50, 8'h35, {26{8'h00}}},
    {8'h44, 8'h49, 8'h43, 8'h4D, {24{8'h00}}},
    {8'h4D, 8'h6F, 8'h64, 8'h61, 8'h6C, 8'h69, 8'h74, 8'h79, 8'h20, 8'h3A,
     8'h3D, {17{8'h00}}},
    {8'h23, 8'h20, 8'h41, 8'h6D, 8'h69, 8'h72, 8'h61, 8'h4D, 8'h65, 8'h73,
     8'h68, 8'h20, 8'h33, 8'h44, {14{8'h00}}},
    {8'h39, 8'h30, {26{8'h00}}},
    {8'h6E, 8'h69, 8'h31, 8'h00, {24{8'h00}}},
    {8'h6E, 8'h2B, 8'h31, 8'h00, {24{8'h00}}},
    {8'h41, 8'h56, 8'h57, 8'h5F, 8'h49, 8'h6D, 8'h61, 8'h67, 8'h65, 8'h46,
     8'h69, 8'h6C, 8'h65, {15{8'h00}}},
    {8'h4E, 8'h52, 8'h52, 8'h44, {24{8'h00}}},
    {8'h5C, 8'h01, 8'h00, 8'h00, {24{8'h00}}},
    {8'h00, 8'h00, 8'h01, 8'h5C, {24{8'h00}}},
    {8'h23, 8'h49, 8'h6E, 8'h73, 8'h69, 8'h67, 8'h68, 8'h74, 8'h20, 8'h54,
     8'h72, 8'h61, 8'h6E, 8'h73, 8'h66, 8'h6F, 8'h72, 8'h6D, 8'h20, 8'h46,
     8'h69, 8'h6C, 8'h65, 8'h20, 8'h56, 8'h31, 8'h2E, 8'h30}
  };

  // Expected byte of signature sig at index idx within the signature.
  function automatic logic [7:0] sig_byte(input int sig, input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (idx < IDX_W'(SIG_MAX_LEN)) begin
      b = SIG_BYTES[sig][(SIG_MAX_LEN - 1 - int'(idx)) * 8 +: 8];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/header_magic_signature_matcher_top.sv */
`default_nettype none

// Channel  Handshake            Payload
// -------  -------------------  -------------------------------
// in       in_valid / in_ready  header_byte[7:0], last_byte
// out      out_valid/out_ready  format_code[3:0]
//
// One byte per cycle while in_ready is high; the result is registered and is valid in
// the cycle after the byte marked last is taken. All 13 byte comparators work in parallel on
// the current position, so throughput is set only by the output register.
// Reset clears the position counter and out_valid and sets all match flags.
// A stalled result holds in_ready low only while the output register is full.

module header_magic_signature_matcher_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  header_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output hmsm_pkg::code_t  format_code
);

  hmsm_pkg::pos_t      byte_position;
  hmsm_pkg::pos_t      byte_position_next;
  hmsm_pkg::sig_mask_t signature_alive;
  hmsm_pkg::sig_mask_t signature_alive_next;
  hmsm_pkg::sig_mask_t mismatch;
  hmsm_pkg::sig_mask_t final_alive;
  hmsm_pkg::code_t     code_next;
  logic                accept;

  logic [hmsm_pkg::POS_W-1:0] rel_pos [hmsm_pkg::NUM_SIGS];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    mismatch = '0;
    for (int s = 0; s < hmsm_pkg::NUM_SIGS; s++) begin
      rel_pos[s] = byte_position - hmsm_pkg::SIG_OFFSET[s];
      if (byte_position < hmsm_pkg::HEADER_BYTES &&
          byte_position >= hmsm_pkg::SIG_OFFSET[s] &&
          rel_pos[s] < hmsm_pkg::POS_W'(hmsm_pkg::SIG_LENGTH[s]) &&
          hmsm_pkg::sig_byte(s, rel_pos[s][hmsm_pkg::IDX_W-1:0]) != header_byte) begin
        mismatch[s] = 1'b1;
      end
    end
  end

  assign signature_alive_next = signature_alive & ~mismatch;

  // Drop any signature that still needs a nonzero byte past the end of the file.
  always_comb begin
    final_alive = signature_alive_next;
    for (int s = 0; s < hmsm_pkg::NUM_SIGS; s++) begin
      if (byte_position < hmsm_pkg::SIG_NEED[s]) begin
        final_alive[s] = 1'b0;
      end
    end
  end

  // First surviving signature in table order wins.
  always_comb begin
    code_next = hmsm_pkg::CODE_UNKNOWN;
    for (int s = hmsm_pkg::NUM_SIGS - 1; s >= 0; s--) begin
      if (final_alive[s]) begin
        code_next = hmsm_pkg::CODE_W'(s + 1);
      end
    end
  end

  assign byte_position_next = (byte_position == hmsm_pkg::POS_MAX) ?
                              byte_position : byte_position + hmsm_pkg::POS_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      signature_alive <= '1;
    end else if (accept) begin
      if (last_byte) begin
        byte_position   <= '0;
        signature_alive <= '1;
      end else begin
        byte_position   <= byte_position_next;
        signature_alive <= signature_alive_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      format_code <= code_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/hmsm_checker.sv */
`default_nettype none

module hmsm_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            last_byte,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire hmsm_pkg::code_t format_code
);

  // A stalled result holds its code.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(format_code))
    else $error("format_code changed while stalled");

  // Every transfer of a last byte yields a result next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_byte |=> out_valid)
    else $error("no result after last byte");

  // A new result only follows a last-byte transfer.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && last_byte && !rst))
    else $error("result without last byte");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> format_code <= hmsm_pkg::CODE_W'(hmsm_pkg::NUM_SIGS))
    else $error("format_code out of range");

  // An empty or draining output register never blocks input.
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("in_ready low with free output");

endmodule

bind header_magic_signature_matcher_top hmsm_checker u_hmsm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .last_byte   (last_byte),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .format_code (format_code)
);

`default_nettype wire

/* test/header_magic_signature_matcher_checker.sv */
package hmsm_check_pkg;

  localparam int SIG_COUNT = 13;
  localparam int SIG_SPAN = 28;
  localparam int HEADER_LIMIT = 348;
  localparam int POS_TOP = 511;

  typedef enum logic [3:0] {
    FMT_UNKNOWN,
    FMT_TYPED_STREAM,
    FMT_PGM,
    FMT_DICOM,
    FMT_MODALITY,
    FMT_MESH_TEXT,
    FMT_PIC,
    FMT_NIFTI_PAIR,
    FMT_NIFTI_SINGLE,
    FMT_AVW,
    FMT_NRRD,
    FMT_ANALYZE_LE,
    FMT_ANALYZE_BE,
    FMT_XFORM_TEXT
  } fmt_e;

  // Entry s describes format code s+1.
  localparam int SIG_START [SIG_COUNT] = '{0, 0, 128, 0, 0, 54, 344, 344, 0, 0, 0, 0, 0};
  localparam int SIG_LEN [SIG_COUNT] = '{13, 2, 4, 11, 14, 2, 4, 4, 13, 4, 4, 4, 28};

  // First signature byte sits in the top byte lane.
  localparam logic [8*SIG_SPAN-1:0] SIG_TEXT [SIG_COUNT] = '{
    {"! TYPEDSTREAM", {15{8'h00}}},
    {"P5", {26{8'h00}}},
    {"DICM", {24{8'h00}}},
    {"Modality :=", {17{8'h00}}},
    {8'h23, 8'h20, 8'h41, 8'h6D, 8'h69, 8'h72, 8'h61, 8'h4D, 8'h65, 8'h73,
     8'h68, 8'h20, 8'h33, 8'h44, {14{8'h00}}},
    {8'h39, 8'h30, {26{8'h00}}},
    {"ni1", 8'h00, {24{8'h00}}},
    {"n+1", 8'h00, {24{8'h00}}},
    {8'h41, 8'h56, 8'h57, 8'h5F, 8'h49, 8'h6D, 8'h61, 8'h67, 8'h65, 8'h46,
     8'h69, 8'h6C, 8'h65, {15{8'h00}}},
    {"NRRD", {24{8'h00}}},
    {8'h5C, 8'h01, 8'h00, 8'h00, {24{8'h00}}},
    {8'h00, 8'h00, 8'h01, 8'h5C, {24{8'h00}}},
    {8'h23, 8'h49, 8'h6E, 8'h73, 8'h69, 8'h67, 8'h68, 8'h74, 8'h20, 8'h54,
     8'h72, 8'h61, 8'h6E, 8'h73, 8'h66, 8'h6F, 8'h72, 8'h6D, 8'h20, 8'h46,
     8'h69, 8'h6C, 8'h65, 8'h20, 8'h56, 8'h31, 8'h2E, 8'h30}
  };

  function automatic logic [7:0] sig_at(input int s, input int k);
    return SIG_TEXT[s][8*(SIG_SPAN-1-k) +: 8];
  endfunction

endpackage

module header_magic_signature_matcher_checker
  import hmsm_check_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            header_byte,
  input  logic                  last_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  hmsm_pkg::code_t       format_code,
  output int                    mismatches,
  output int                    results_due,
  output logic [SIG_COUNT:0]    codes_hit
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [8:0]           byte_pos = '0;
  logic [SIG_COUNT-1:0] sig_live = '1;
  fmt_e                 expected_formats [$];
  int                   fail_total = 0;
  logic [SIG_COUNT:0]   seen_codes = '0;

  always @(posedge clk) begin : track
    logic [SIG_COUNT-1:0] live;
    int pos;
    int s;
    int k;
    fmt_e verdict;
    fmt_e oldest;
    if (rst) begin
      byte_pos <= '0;
      sig_live <= '1;
      expected_formats.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_formats.size() == 0) begin
          $error("format_code: expected none, actual %0d", format_code);
          fail_total++;
        end else begin
          oldest = expected_formats.pop_front();
          if (format_code !== oldest) begin
            $error("format_code: expected %0d, actual %0d", oldest, format_code);
            fail_total++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pos = int'(byte_pos);
        live = sig_live;
        if (pos < HEADER_LIMIT) begin
          for (s = 0; s < SIG_COUNT; s++) begin
            if (pos >= SIG_START[s] && pos < SIG_START[s] + SIG_LEN[s] &&
                header_byte != sig_at(s, pos - SIG_START[s])) begin
              live[s] = 1'b0;
            end
          end
        end
        if (last_byte) begin
          // Positions never received read as zero bytes.
          for (s = 0; s < SIG_COUNT; s++) begin
            for (k = 0; k < SIG_LEN[s]; k++) begin
              if (SIG_START[s] + k > pos && sig_at(s, k) != 8'h00) live[s] = 1'b0;
            end
          end
          verdict = FMT_UNKNOWN;
          for (s = SIG_COUNT - 1; s >= 0; s--) begin
            if (live[s]) verdict = fmt_e'(4'(s + 1));
          end
          expected_formats.push_back(verdict);
          seen_codes[verdict] = 1'b1;
          byte_pos <= '0;
          sig_live <= '1;
        end else begin
          byte_pos <= (pos == POS_TOP) ? byte_pos : byte_pos + 9'd1;
          sig_live <= live;
        end
      end
    end
    mismatches <= fail_total;
    results_due <= expected_formats.size();
    codes_hit <= seen_codes;
  end

endmodule

/* test/header_magic_signature_matcher_top_test.sv */
module header_magic_signature_matcher_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  import hmsm_check_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 12;
  localparam int LONG_HOLD = 250;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int BYTE_BUDGET = 1100;
  localparam int MIN_HEADERS = 26;
  localparam int IMAGE_MAX = 600;

  typedef enum int {DRAIN_FREE, DRAIN_COIN, DRAIN_EVERY_NTH, DRAIN_MOSTLY} drain_mode_e;

  localparam fmt_e SHORT_FORMATS [9] = '{
    FMT_TYPED_STREAM, FMT_PGM, FMT_MODALITY, FMT_MESH_TEXT, FMT_AVW,
    FMT_NRRD, FMT_ANALYZE_LE, FMT_ANALYZE_BE, FMT_XFORM_TEXT
  };

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [7:0]      header_byte = '0;
  logic            last_byte = 1'b0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  hmsm_pkg::code_t format_code;

  int                 mismatches;
  int                 results_due;
  logic [SIG_COUNT:0] codes_hit;

  logic [7:0] image [IMAGE_MAX];
  int         image_len = 0;
  int         bytes_sent = 0;
  int         headers_sent = 0;
  int         burst_left = 0;
  bit         steady = 1'b0;
  int         quiet_cycles = 0;

  header_magic_signature_matcher_top DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .header_byte (header_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .format_code (format_code)
  );

  header_magic_signature_matcher_checker format_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .header_byte (header_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .format_code (format_code),
    .mismatches  (mismatches),
    .results_due (results_due),
    .codes_hit   (codes_hit)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: one long hold-off right after reset, then random stall patterns.
  initial begin : drain
    drain_mode_e mode;
    int seg;
    int period;
    int k;
    while (rst) @(posedge clk);
    repeat (LONG_HOLD) @(posedge clk);
    forever begin
      mode = drain_mode_e'($urandom_range(0, 3));
      seg = $urandom_range(20, 150);
      period = $urandom_range(2, 5);
      for (k = 0; k < seg; k++) begin
        case (mode)
          DRAIN_FREE: begin
            out_ready <= 1'b1;
          end
          DRAIN_COIN: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          DRAIN_EVERY_NTH: begin
            out_ready <= (k % period == 0);
          end
          default: begin
            out_ready <= ($urandom_range(0, 3) != 0);
          end
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic offer_byte(input logic [7:0] b, input logic fin);
    if (!steady && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    header_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic clear_header(input int n, input bit zeros);
    int i;
    image_len = n;
    for (i = 0; i < n; i++) image[i] = zeros ? 8'h00 : 8'($urandom);
  endtask

  // Bytes past image_len are written but never sent.
  task automatic write_signature(input fmt_e f);
    int s;
    int k;
    s = int'(f) - 1;
    for (k = 0; k < SIG_LEN[s]; k++) image[SIG_START[s] + k] = sig_at(s, k);
  endtask

  task automatic stream_header();
    int i;
    for (i = 0; i < image_len; i++) offer_byte(image[i], i == image_len - 1);
    headers_sent++;
  endtask

  task automatic random_header();
    fmt_e f;
    int s;
    int span;
    int lo;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      clear_header($urandom_range(1, 30), 1'b0);
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 6) f = FMT_DICOM;
      else if (roll < 14) f = FMT_PIC;
      else f = SHORT_FORMATS[$urandom_range(0, 8)];
      s = int'(f) - 1;
      span = SIG_START[s] + SIG_LEN[s];
      if ($urandom_range(0, 4) == 0) begin
        // cut the header inside the signature
        lo = (SIG_START[s] > 0) ? SIG_START[s] : 1;
        clear_header($urandom_range(lo, span - 1), 1'($urandom_range(0, 2) == 0));
      end else begin
        clear_header(span + $urandom_range(0, 3), 1'($urandom_range(0, 2) == 0));
      end
      write_signature(f);
      if ($urandom_range(0, 3) == 0) write_signature(fmt_e'(4'($urandom_range(1, SIG_COUNT))));
      if ($urandom_range(0, 4) == 0) begin
        image[SIG_START[s] + $urandom_range(0, SIG_LEN[s] - 1)] ^= 8'(1 << $urandom_range(0, 7));
      end
    end
    stream_header();
  endtask

  initial begin : stimulus
    int failures;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    image_len = 1;
    image[0] = 8'hFF;
    stream_header();
    image_len = 1;
    image[0] = 8'h00;
    stream_header();
    clear_header(2, 1'b1);
    write_signature(FMT_PGM);
    stream_header();
    clear_header(1, 1'b1);
    write_signature(FMT_PGM);
    stream_header();
    // trailing zero bytes of the signature are never sent
    clear_header(2, 1'b1);
    write_signature(FMT_ANALYZE_LE);
    stream_header();
    clear_header(4, 1'b1);
    write_signature(FMT_ANALYZE_BE);
    stream_header();
    clear_header(4, 1'b0);
    write_signature(FMT_NRRD);
    stream_header();

    while (bytes_sent < BYTE_BUDGET || headers_sent < MIN_HEADERS) begin
      steady = ($urandom_range(0, 5) == 0);
      if (headers_sent == 12) begin
        clear_header(HEADER_LIMIT - 1, 1'($urandom_range(0, 1)));
        write_signature(FMT_NIFTI_PAIR);
        stream_header();
      end else if (headers_sent == 24) begin
        // run the position counter into saturation
        clear_header($urandom_range(POS_TOP + 1, POS_TOP + 9), 1'b0);
        write_signature(FMT_NIFTI_SINGLE);
        stream_header();
      end else begin
        random_header();
      end
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    failures = mismatches;
    if (results_due != 0) begin
      $error("format_code: expected %0d more results, actual none", results_due);
      failures += results_due;
    end
    $display("Run: %0d header bytes in %0d headers, incl. short, cut, corrupt and long ones.",
             bytes_sent, headers_sent);
    $display("Format codes predicted (bit n = code n): %b", codes_hit);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/hmsm_pkg.sv
rtl/header_magic_signature_matcher_top.sv
rtl/hmsm_checker.sv
test/header_magic_signature_matcher_checker.sv
test/header_magic_signature_matcher_top_test.sv
